/* sv/pthc_pkg.sv */
// ----------------------------------------------------------------------------
// pthc_pkg: shared types, constants and arithmetic helpers
// Calibration record, item record, divider records and 32-bit wrap helpers.
// ----------------------------------------------------------------------------
package pthc_pkg;

	localparam int unsigned DIV_STEPS = 32;

	localparam logic [2:0] REG_CAL_T    = 3'd0;
	localparam logic [2:0] REG_CAL_PLO  = 3'd1;
	localparam logic [2:0] REG_CAL_PHI  = 3'd2;
	localparam logic [2:0] REG_CAL_MIX  = 3'd3;
	localparam logic [2:0] REG_CAL_HOFS = 3'd4;

	localparam logic [31:0] P_OFFSET  = 32'd64000;
	localparam logic [31:0] P_BASE    = 32'd1048576;
	localparam logic [31:0] P_SCALE   = 32'd3125;
	localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
	localparam logic [31:0] H_OFFSET  = 32'd76800;
	localparam logic [31:0] H_LIMIT   = 32'd419430400;
	localparam logic [31:0] H_C_OFS   = 32'd2097152;
	localparam logic [31:0] H_B_OFS   = 32'd32768;
	localparam logic [31:0] H_RND_A   = 32'd16384;
	localparam logic [31:0] H_RND_D   = 32'd8192;
	localparam logic [31:0] T_RND     = 32'd128;
	localparam logic [31:0] T_MIN     = -32'sd4000;
	localparam logic [31:0] T_MAX     = 32'sd8500;
	localparam logic [31:0] P_MAX     = 32'd131071;

	typedef struct packed {
		logic [31:0] t1, t2, t3;
		logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6;
	} cal_t;

	typedef struct packed {
		logic [19:0] ap;
		logic [19:0] at;
		logic [15:0] ah;
	} item_t;

	typedef struct packed {
		logic [14:0] temp;
		logic [16:0] hum;
		logic        dz;
		logic        post;
	} div_side_t;

	typedef struct packed {
		logic [31:0] num;
		logic [31:0] den;
		div_side_t   side;
	} div_in_t;

	function automatic logic [31:0] sar(input logic [31:0] x, input int unsigned n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		return a * b;
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

endpackage

/* sv/pthc_front.sv */
// ----------------------------------------------------------------------------
// pthc_front: calibration registers and input queue
// Holds the calibration words, unpacks their fields and buffers items.
// ----------------------------------------------------------------------------
module pthc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  pthc_pkg::item_t  in_item,
	output logic             q_valid,
	input  logic             q_take,
	output pthc_pkg::item_t  q_item,
	output pthc_pkg::cal_t   cal
);
	import pthc_pkg::*;

	logic [47:0] cal_t_q;
	logic [63:0] cal_plo_q;
	logic [63:0] cal_phi_q;
	logic [55:0] cal_mix_q;
	logic [31:0] cal_hofs_q;

	item_t       buf_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t_q    <= '0;
			cal_plo_q  <= '0;
			cal_phi_q  <= '0;
			cal_mix_q  <= '0;
			cal_hofs_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAL_T:    cal_t_q    <= cfg_data[47:0];
				REG_CAL_PLO:  cal_plo_q  <= cfg_data;
				REG_CAL_PHI:  cal_phi_q  <= cfg_data;
				REG_CAL_MIX:  cal_mix_q  <= cfg_data[55:0];
				REG_CAL_HOFS: cal_hofs_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cal.t1 = {16'b0, cal_t_q[15:0]};
	assign cal.t2 = sx16(cal_t_q[31:16]);
	assign cal.t3 = sx16(cal_t_q[47:32]);
	assign cal.p1 = {16'b0, cal_plo_q[15:0]};
	assign cal.p2 = sx16(cal_plo_q[31:16]);
	assign cal.p3 = sx16(cal_plo_q[47:32]);
	assign cal.p4 = sx16(cal_plo_q[63:48]);
	assign cal.p5 = sx16(cal_phi_q[15:0]);
	assign cal.p6 = sx16(cal_phi_q[31:16]);
	assign cal.p7 = sx16(cal_phi_q[47:32]);
	assign cal.p8 = sx16(cal_phi_q[63:48]);
	assign cal.p9 = sx16(cal_mix_q[15:0]);
	assign cal.h1 = {24'b0, cal_mix_q[23:16]};
	assign cal.h2 = sx16(cal_mix_q[39:24]);
	assign cal.h3 = {24'b0, cal_mix_q[47:40]};
	assign cal.h6 = sx8(cal_mix_q[55:48]);
	assign cal.h4 = sx16(cal_hofs_q[15:0]);
	assign cal.h5 = sx16(cal_hofs_q[31:16]);

	// two-entry item queue
	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_take;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* sv/pthc_div.sv */
// ----------------------------------------------------------------------------
// pthc_div: pipelined unsigned 32/32 divider
// One quotient bit per stage, restoring form; sideband rides along.
// ----------------------------------------------------------------------------
module pthc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  pthc_pkg::div_in_t   din,
	output logic                out_vld,
	output logic [31:0]         quo,
	output pthc_pkg::div_side_t side
);
	import pthc_pkg::*;

	logic [31:0] rem_q  [DIV_STEPS];
	logic [31:0] num_q  [DIV_STEPS];
	logic [31:0] den_q  [DIV_STEPS];
	logic [31:0] quo_q  [DIV_STEPS];
	div_side_t   side_q [DIV_STEPS];
	logic [DIV_STEPS-1:0] vld_q;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [31:0] r_in, n_in, d_in, q_in;
		div_side_t   s_in;
		logic        v_in;
		logic [32:0] rs, diff;
		logic        ge;

		if (k == 0) begin : g_first
			assign r_in = '0;
			assign n_in = din.num;
			assign d_in = din.den;
			assign q_in = '0;
			assign s_in = din.side;
			assign v_in = in_vld;
		end else begin : g_next
			assign r_in = rem_q[k-1];
			assign n_in = num_q[k-1];
			assign d_in = den_q[k-1];
			assign q_in = quo_q[k-1];
			assign s_in = side_q[k-1];
			assign v_in = vld_q[k-1];
		end

		assign rs   = {r_in, n_in[31]};
		assign diff = rs - {1'b0, d_in};
		assign ge   = (rs >= {1'b0, d_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? diff[31:0] : rs[31:0];
				num_q[k]  <= {n_in[30:0], 1'b0};
				den_q[k]  <= d_in;
				quo_q[k]  <= {q_in[30:0], ge};
				side_q[k] <= s_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= v_in;
			end
		end
	end

	assign out_vld = vld_q[DIV_STEPS-1];
	assign quo     = quo_q[DIV_STEPS-1];
	assign side    = side_q[DIV_STEPS-1];

endmodule

/* sv/pthc_back.sv */
// ----------------------------------------------------------------------------
// pthc_back: compensation pipeline and output register
// Temperature, humidity and pressure formulas in registered stages.
// ----------------------------------------------------------------------------
module pthc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  pthc_pkg::cal_t    cal,
	input  logic              q_valid,
	output logic              q_take,
	input  pthc_pkg::item_t   q_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [14:0] temperature_centi,
	output logic [16:0]       pressure_pa,
	output logic [16:0]       humidity_q10,
	output logic              divisor_zero
);
	import pthc_pkg::*;

	logic        adv;
	logic [13:0] vld_pipe_q;
	logic        vld15_q, vld16_q, out_valid_q;
	logic        vld15_in_w;

	logic [19:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7;
	logic [15:0] ah_s1, ah_s2, ah_s3, ah_s4, ah_s5;
	logic [31:0] m1_s1, qq_s1, v1t_s2, m2_s2, fine_s3;
	logic [14:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9, temp_s10;
	logic [14:0] temp_s11, temp_s12, temp_s13, temp_s14;
	logic [31:0] pv1_s4, hx_s4;
	logic [31:0] sq_s5, mp5_s5, mp2_s5, mh5_s5, mh3_s5, mh6_s5;
	logic [31:0] v2a_s6, mp3_s6, mp5_s6, mp2_s6, ha_s6, hb_s6, hc1_s6;
	logic [31:0] v2b_s7, pv1b_s7, hcm_s7, ha_s7;
	logic [31:0] pm_s8, pp_s8, hc_s8, ha_s8;
	logic [31:0] dv_s9, p0_s9, hcd_s9, ha_s9;
	logic [31:0] hd_s10, ha_s10, dv_s10, p0_s10;
	logic [31:0] hx_s11, dv_s11, p0_s11;
	logic [31:0] hss_s12, hx_s12, dv_s12, p0_s12;
	logic [31:0] ht_s13, hx_s13, dv_s13, p0_s13;
	logic [16:0] hum_s14;
	logic [31:0] dv_s14, p0_s14;

	logic [31:0] t_a, t_q, tw, fine5, pq, v2sum, pv1sum, x2;
	logic [31:0] hum_x;

	div_in_t     div_in;
	logic        div_vld;
	logic [31:0] div_quo;
	div_side_t   div_side;
	logic [31:0] pfix;

	logic [31:0] p_s15, pa_s15, pm8_s15;
	div_side_t   side_s15, side_s16;
	logic [31:0] p_s16, pm8_s16, m9_s16;
	logic [31:0] pfin;
	logic [16:0] press;

	// whole pipeline moves together; the output register frees it
	assign adv    = !out_valid_q || out_ready;
	assign q_take = adv;

	assign t_a   = ({12'b0, q_item.at} >> 3) - (cal.t1 << 1);
	assign t_q   = ({12'b0, q_item.at} >> 4) - cal.t1;
	assign fine5 = fine_s3 + (fine_s3 << 2) + T_RND;
	assign tw    = sar(fine5, 8);
	assign pq    = sar(pv1_s4, 2);
	assign v2sum = sar(v2a_s6 + (mp5_s6 << 1), 2) + (cal.p4 << 16);
	assign pv1sum = sar(sar(mp3_s6, 3) + sar(mp2_s6, 1), 18);
	assign hum_x = ({16'b0, ah_s5} << 14) - (cal.h4 << 20) - mh5_s5 + H_RND_A;
	assign x2    = hx_s13 - sar(ht_s13, 4);

	always_ff @(posedge clk) begin
		if (adv) begin
			// temperature
			ap_s1   <= q_item.ap;
			ah_s1   <= q_item.ah;
			m1_s1   <= mul32(t_a, cal.t2);
			qq_s1   <= mul32(t_q, t_q);
			ap_s2   <= ap_s1;
			ah_s2   <= ah_s1;
			v1t_s2  <= sar(m1_s1, 11);
			m2_s2   <= mul32(sar(qq_s1, 12), cal.t3);
			ap_s3   <= ap_s2;
			ah_s3   <= ah_s2;
			fine_s3 <= v1t_s2 + sar(m2_s2, 14);
			ap_s4   <= ap_s3;
			ah_s4   <= ah_s3;
			if ($signed(tw) < $signed(T_MIN)) begin
				temp_s4 <= T_MIN[14:0];
			end else if ($signed(tw) > $signed(T_MAX)) begin
				temp_s4 <= T_MAX[14:0];
			end else begin
				temp_s4 <= tw[14:0];
			end
			pv1_s4  <= sar(fine_s3, 1) - P_OFFSET;
			hx_s4   <= fine_s3 - H_OFFSET;
			// products of the fine-temperature terms
			ap_s5   <= ap_s4;
			ah_s5   <= ah_s4;
			temp_s5 <= temp_s4;
			sq_s5   <= mul32(pq, pq);
			mp5_s5  <= mul32(pv1_s4, cal.p5);
			mp2_s5  <= mul32(cal.p2, pv1_s4);
			mh5_s5  <= mul32(cal.h5, hx_s4);
			mh3_s5  <= mul32(hx_s4, cal.h3);
			mh6_s5  <= mul32(hx_s4, cal.h6);
			ap_s6   <= ap_s5;
			temp_s6 <= temp_s5;
			v2a_s6  <= mul32(sar(sq_s5, 11), cal.p6);
			mp3_s6  <= mul32(cal.p3, sar(sq_s5, 13));
			mp5_s6  <= mp5_s5;
			mp2_s6  <= mp2_s5;
			ha_s6   <= sar(hum_x, 15);
			hb_s6   <= sar(mh3_s5, 11) + H_B_OFS;
			hc1_s6  <= sar(mh6_s5, 10);
			ap_s7   <= ap_s6;
			temp_s7 <= temp_s6;
			v2b_s7  <= v2sum;
			pv1b_s7 <= pv1sum;
			hcm_s7  <= mul32(hc1_s6, hb_s6);
			ha_s7   <= ha_s6;
			temp_s8 <= temp_s7;
			pm_s8   <= mul32(H_B_OFS + pv1b_s7, cal.p1);
			pp_s8   <= (P_BASE - {12'b0, ap_s7}) - sar(v2b_s7, 12);
			hc_s8   <= sar(hcm_s7, 10) + H_C_OFS;
			ha_s8   <= ha_s7;
			temp_s9 <= temp_s8;
			dv_s9   <= sar(pm_s8, 15);
			p0_s9   <= mul32(pp_s8, P_SCALE);
			hcd_s9  <= mul32(hc_s8, cal.h2);
			ha_s9   <= ha_s8;
			// humidity tail; pressure divisor waits alongside
			temp_s10 <= temp_s9;
			hd_s10   <= sar(hcd_s9 + H_RND_D, 14);
			ha_s10   <= ha_s9;
			dv_s10   <= dv_s9;
			p0_s10   <= p0_s9;
			temp_s11 <= temp_s10;
			hx_s11   <= mul32(ha_s10, hd_s10);
			dv_s11   <= dv_s10;
			p0_s11   <= p0_s10;
			temp_s12 <= temp_s11;
			hss_s12  <= mul32(sar(hx_s11, 15), sar(hx_s11, 15));
			hx_s12   <= hx_s11;
			dv_s12   <= dv_s11;
			p0_s12   <= p0_s11;
			temp_s13 <= temp_s12;
			ht_s13   <= mul32(sar(hss_s12, 7), cal.h1);
			hx_s13   <= hx_s12;
			dv_s13   <= dv_s12;
			p0_s13   <= p0_s12;
			temp_s14 <= temp_s13;
			if (x2[31]) begin
				hum_s14 <= '0;
			end else if (x2 > H_LIMIT) begin
				hum_s14 <= H_LIMIT[28:12];
			end else begin
				hum_s14 <= x2[28:12];
			end
			dv_s14   <= dv_s13;
			p0_s14   <= p0_s13;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pipe_q <= '0;
		end else if (adv) begin
			vld_pipe_q <= {vld_pipe_q[12:0], q_valid};
		end
	end

	// dividend doubled up front unless that would overflow
	assign div_vld        = vld_pipe_q[13];
	assign div_in.num     = p0_s14[31] ? p0_s14 : (p0_s14 << 1);
	assign div_in.den     = dv_s14;
	assign div_in.side.temp = temp_s14;
	assign div_in.side.hum  = hum_s14;
	assign div_in.side.dz   = (dv_s14 == '0);
	assign div_in.side.post = p0_s14[31];

	pthc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (div_vld),
		.din     (div_in),
		.out_vld (vld15_in_w),
		.quo     (div_quo),
		.side    (div_side)
	);

	assign pfix = div_side.post ? (div_quo << 1) : div_quo;
	assign pfin = p_s16 + sar(sar(m9_s16, 12) + sar(pm8_s16, 13) + cal.p7, 4);
	assign press = (pfin > P_MAX) ? P_MAX[16:0] : pfin[16:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s15    <= pfix;
			pa_s15   <= mul32(pfix >> 3, pfix >> 3);
			pm8_s15  <= mul32(pfix >> 2, cal.p8);
			side_s15 <= div_side;
			p_s16    <= p_s15;
			pm8_s16  <= pm8_s15;
			m9_s16   <= mul32(cal.p9, pa_s15 >> 13);
			side_s16 <= side_s15;
			temperature_centi <= side_s16.temp;
			humidity_q10      <= side_s16.hum;
			divisor_zero      <= side_s16.dz;
			pressure_pa       <= side_s16.dz ? '0 : press;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld15_q     <= 1'b0;
			vld16_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld15_q     <= vld15_in_w;
			vld16_q     <= vld15_q;
			out_valid_q <= vld16_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/pth_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// pth_sensor_compensation: pressure, temperature and humidity compensation
// 32-bit integer compensation of raw converter values with calibration words.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | adc_pressure, adc_temperature, adc_humidity
//  out     | out_valid / out_ready | temperature_centi, pressure_pa,
//          |                       | humidity_q10, divisor_zero
//  cfg     | cfg_we (no wait)      | cfg_index, cfg_data
//
// One item per cycle sustained while out_ready stays high; out_valid rises once the
// accepted item has passed the queue register, 14 arithmetic stages, the 32-stage
// pressure divider and two multiplier stages plus the output register after it.
// Reset clears the calibration words to zero and empties queue and pipeline.
// A stalled output freezes the whole back pipeline; the two-entry input queue
// keeps taking items until it fills.
// ----------------------------------------------------------------------------
module pth_sensor_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [19:0]        adc_pressure,
	input  logic [19:0]        adc_temperature,
	input  logic [15:0]        adc_humidity,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] temperature_centi,
	output logic [16:0]        pressure_pa,
	output logic [16:0]        humidity_q10,
	output logic               divisor_zero
);
	import pthc_pkg::*;

	item_t in_item, q_item;
	cal_t  cal;
	logic  q_valid, q_take;

	// pack the raw fields into one item
	assign in_item.ap = adc_pressure;
	assign in_item.at = adc_temperature;
	assign in_item.ah = adc_humidity;

	// front: calibration registers and item queue
	pthc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_item    (q_item),
		.cal       (cal)
	);

	// back: arithmetic pipeline, divider and output register
	pthc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cal               (cal),
		.q_valid           (q_valid),
		.q_take            (q_take),
		.q_item            (q_item),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature_centi (temperature_centi),
		.pressure_pa       (pressure_pa),
		.humidity_q10      (humidity_q10),
		.divisor_zero      (divisor_zero)
	);

endmodule

/* sv/pthc_checker.sv */
// ----------------------------------------------------------------------------
// pthc_checker: port-level checks
// Output hold, result ranges and the zero-divisor rule.
// ----------------------------------------------------------------------------
module pthc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [14:0] temperature_centi,
	input logic [16:0]        pressure_pa,
	input logic [16:0]        humidity_q10,
	input logic               divisor_zero
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure_pa))
		else $error("output item dropped while stalled");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_centi >= -15'sd4000 && temperature_centi <= 15'sd8500)
		else $error("temperature out of range");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divisor_zero |-> pressure_pa == 17'd0)
		else $error("pressure not forced to zero");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_q10 <= 17'd102400)
		else $error("humidity out of range");

endmodule

bind pth_sensor_compensation pthc_checker u_pthc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.temperature_centi (temperature_centi),
	.pressure_pa       (pressure_pa),
	.humidity_q10      (humidity_q10),
	.divisor_zero      (divisor_zero)
);

/* verif/pth_sensor_compensation_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_sensor_compensation_checker: result predictor and scoreboard
// Mirrors the calibration writes, predicts temperature, pressure and humidity
// for every accepted item and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module pth_sensor_compensation_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [19:0]        adc_pressure,
	input  logic [19:0]        adc_temperature,
	input  logic [15:0]        adc_humidity,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [14:0] temperature_centi,
	input  logic [16:0]        pressure_pa,
	input  logic [16:0]        humidity_q10,
	input  logic               divisor_zero,
	output int                 fails,
	output int                 pending
);
	import pthc_pkg::*;

	typedef struct packed {
		logic signed [14:0] temp;
		logic [16:0]        press;
		logic [16:0]        hum;
		logic               dz;
	} reading_t;

	logic [47:0] cal_temp;
	logic [63:0] cal_plo, cal_phi;
	logic [55:0] cal_mix;
	logic [31:0] cal_hofs;
	reading_t    expected_readings[$];
	int          seen;

	function automatic logic [31:0] asr(input logic [31:0] x, input int n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] wide16(input logic [15:0] v);
		return $unsigned(32'($signed(v)));
	endfunction

	function automatic logic [31:0] wide8(input logic [7:0] v);
		return $unsigned(32'($signed(v)));
	endfunction

	function automatic reading_t compensate(input logic [19:0] ap_in, input logic [19:0] at_in,
			input logic [15:0] ah_in);
		logic [31:0] ap, at, ah;
		logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] h1, h2, h3, h4, h5, h6;
		logic [31:0] v1, v2, q, sq, fine, p, x, a, b, c, d, s, tw;
		int          ts;
		reading_t    r;
		ap = 32'(ap_in);
		at = 32'(at_in);
		ah = 32'(ah_in);
		t1 = 32'(cal_temp[15:0]);
		t2 = wide16(cal_temp[31:16]);
		t3 = wide16(cal_temp[47:32]);
		p1 = 32'(cal_plo[15:0]);
		p2 = wide16(cal_plo[31:16]);
		p3 = wide16(cal_plo[47:32]);
		p4 = wide16(cal_plo[63:48]);
		p5 = wide16(cal_phi[15:0]);
		p6 = wide16(cal_phi[31:16]);
		p7 = wide16(cal_phi[47:32]);
		p8 = wide16(cal_phi[63:48]);
		p9 = wide16(cal_mix[15:0]);
		h1 = 32'(cal_mix[23:16]);
		h2 = wide16(cal_mix[39:24]);
		h3 = 32'(cal_mix[47:40]);
		h6 = wide8(cal_mix[55:48]);
		h4 = wide16(cal_hofs[15:0]);
		h5 = wide16(cal_hofs[31:16]);
		r = '0;

		// temperature and fine temperature
		v1 = asr(((at >> 3) - (t1 << 1)) * t2, 11);
		q = (at >> 4) - t1;
		v2 = asr(asr(q * q, 12) * t3, 14);
		fine = v1 + v2;
		tw = asr(fine * 32'd5 + 32'd128, 8);
		ts = $signed(tw);
		if (ts < -4000) ts = -4000;
		if (ts > 8500) ts = 8500;
		r.temp = ts[14:0];

		// pressure
		v1 = asr(fine, 1) - 32'd64000;
		q = asr(v1, 2);
		sq = q * q;
		v2 = asr(sq, 11) * p6;
		v2 = v2 + ((v1 * p5) << 1);
		v2 = asr(v2, 2) + (p4 << 16);
		v1 = asr(asr(p3 * asr(sq, 13), 3) + asr(p2 * v1, 1), 18);
		v1 = asr((32'd32768 + v1) * p1, 15);
		if (v1 == 0) begin
			r.dz = 1'b1;
		end else begin
			p = ((32'd1048576 - ap) - asr(v2, 12)) * 32'd3125;
			if (!p[31]) begin
				p = (p << 1) / v1;
			end else begin
				p = (p / v1) * 32'd2;
			end
			v1 = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
			v2 = asr((p >> 2) * p8, 13);
			p = p + asr(v1 + v2 + p7, 4);
			r.press = (p > 32'd131071) ? 17'h1FFFF : p[16:0];
		end

		// humidity, clamped before the final shift
		x = fine - 32'd76800;
		a = asr((ah << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
		b = asr(x * h3, 11) + 32'd32768;
		c = asr(asr(x * h6, 10) * b, 10) + 32'd2097152;
		d = asr(c * h2 + 32'd8192, 14);
		x = a * d;
		s = asr(x, 15);
		x = x - asr(asr(s * s, 7) * h1, 4);
		if (x[31]) x = 0;
		if (x > 32'd419430400) x = 32'd419430400;
		r.hum = 17'(x >> 12);
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("ERROR result %0d: %s got %0d, want %0d", seen, what, $signed(got),
			$signed(want));
		fails++;
	endtask

	initial begin
		fails = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		reading_t w;
		if (!arst_n) begin
			cal_temp = '0;
			cal_plo = '0;
			cal_phi = '0;
			cal_mix = '0;
			cal_hofs = '0;
			expected_readings.delete();
			seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CAL_T:    cal_temp = cfg_data[47:0];
					REG_CAL_PLO:  cal_plo = cfg_data;
					REG_CAL_PHI:  cal_phi = cfg_data;
					REG_CAL_MIX:  cal_mix = cfg_data[55:0];
					REG_CAL_HOFS: cal_hofs = cfg_data[31:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_readings.push_back(compensate(adc_pressure, adc_temperature,
					adc_humidity));
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					$display("ERROR result %0d arrived with nothing outstanding", seen);
					fails++;
				end else begin
					w = expected_readings.pop_front();
					if (temperature_centi !== w.temp)
						report("temperature_centi", 32'(temperature_centi), 32'(w.temp));
					if (pressure_pa !== w.press)
						report("pressure_pa", 32'(pressure_pa), 32'(w.press));
					if (humidity_q10 !== w.hum)
						report("humidity_q10", 32'(humidity_q10), 32'(w.hum));
					if (divisor_zero !== w.dz)
						report("divisor_zero", 32'(divisor_zero), 32'(w.dz));
				end
				seen++;
			end
		end
		pending = expected_readings.size();
	end

endmodule

/* verif/pth_sensor_compensation_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_sensor_compensation_tb: stimulus and verdict for the compensation block
// Walks several calibration sets (reset zeros, typical, all ones, random),
// sends directed extremes and random measurements under varied back-pressure,
// and leaves prediction and comparison to the checker instance.
// ----------------------------------------------------------------------------
module pth_sensor_compensation_tb;
	import pthc_pkg::*;

	// index past the register list; writes to it must be dropped
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int RAND_PHASES = 6;
	localparam int PER_PHASE = 258;

	logic               clk, arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [63:0]        cfg_data;
	logic               in_valid, in_ready;
	logic [19:0]        adc_pressure, adc_temperature;
	logic [15:0]        adc_humidity;
	logic               out_valid, out_ready;
	logic signed [14:0] temperature_centi;
	logic [16:0]        pressure_pa, humidity_q10;
	logic               divisor_zero;
	int                 fails, pending;

	// idle percentages of each side, and a counted receiver hold-off
	int   send_idle_pct, recv_idle_pct, recv_hold;
	int   items_sent, cal_sets;
	logic hold_req;

	pth_sensor_compensation uut (.*);
	pth_sensor_compensation_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: one ready update per falling edge; a hold request starts a count
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			out_ready <= 1'b0;
			recv_hold <= 200;
		end else if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// hold valid until accepted; idle gaps come before an item is offered
	task automatic send_measurement(input logic [19:0] ap, input logic [19:0] at,
			input logic [15:0] ah);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		adc_pressure <= ap;
		adc_temperature <= at;
		adc_humidity <= ah;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// drop valid and let the pipeline drain before touching calibration
	task automatic drain;
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic load_calibration(input logic [47:0] ct, input logic [63:0] plo,
			input logic [63:0] phi, input logic [55:0] mix, input logic [31:0] hofs);
		logic [2:0]  idx [6];
		logic [63:0] val [6];
		idx = '{REG_CAL_T, REG_CAL_PLO, REG_CAL_PHI, REG_CAL_MIX, REG_CAL_HOFS, REG_UNUSED};
		val = '{64'(ct), plo, phi, 64'(mix), 64'(hofs), {$urandom, $urandom}};
		foreach (idx[i]) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
		cal_sets++;
	endtask

	task automatic send_random;
		if ($urandom_range(99) < 70)
			send_measurement(20'($urandom_range(250000, 650000)),
				20'($urandom_range(400000, 620000)), 16'($urandom_range(15000, 45000)));
		else
			send_measurement(20'($urandom), 20'($urandom), 16'($urandom));
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		adc_pressure = '0;
		adc_temperature = '0;
		adc_humidity = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b0;
		items_sent = 0;
		cal_sets = 0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// calibration still zero after reset: the pressure divisor is zero
		send_measurement(20'd0, 20'd0, 16'd0);
		send_measurement(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_measurement(20'd415148, 20'd519888, 16'd30000);
		drain();

		// typical part calibration, directed corners of the raw fields
		load_calibration({16'(-1000), 16'd26435, 16'd27504},
			{16'd2855, 16'd3024, 16'(-10685), 16'd36477},
			{16'(-14600), 16'd15500, 16'(-7), 16'd140},
			{8'd30, 8'd0, 16'd362, 8'd75, 16'd6000}, {16'd50, 16'd313});
		send_measurement(20'd0, 20'd0, 16'd0);
		send_measurement(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_measurement(20'd0, 20'hFFFFF, 16'd0);
		send_measurement(20'hFFFFF, 20'd0, 16'hFFFF);
		send_measurement(20'd415148, 20'd519888, 16'd30000);
		send_measurement(20'd415148, 20'd300000, 16'd65535);
		send_measurement(20'd415148, 20'd700000, 16'd0);
		send_measurement(20'd100000, 20'd519888, 16'd50000);
		send_measurement(20'd900000, 20'd519888, 16'd10000);
		send_measurement(20'h55555, 20'hAAAAA, 16'h5555);
		send_measurement(20'hAAAAA, 20'h55555, 16'hAAAA);
		drain();

		// every calibration bit set
		load_calibration('1, '1, '1, '1, '1);
		send_measurement(20'd0, 20'd0, 16'd0);
		send_measurement(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
		send_measurement(20'd415148, 20'd519888, 16'd30000);
		drain();

		// random phases; each phase runs both idle mixes and then none
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0)
				load_calibration({16'(-1000), 16'd26435, 16'd27504},
					{16'd2855, 16'd3024, 16'(-10685), 16'd36477},
					{16'(-14600), 16'd15500, 16'(-7), 16'd140},
					{8'd30, 8'd0, 16'd362, 8'd75, 16'd6000}, {16'd50, 16'd313});
			else if (ph == 1)
				// small positive P1 and zero P2/P3 keep the divisor small and nonzero
				load_calibration(48'($urandom), {16'd0, 16'd0, 16'd0, 16'd1},
					{$urandom, $urandom}, {$urandom, $urandom}, $urandom);
			else
				load_calibration({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom}, $urandom);
			for (int k = 0; k < PER_PHASE; k++) begin
				if (k < PER_PHASE / 3) begin
					send_idle_pct = 27;
					recv_idle_pct = 75;
				end else if (k < 2 * PER_PHASE / 3) begin
					send_idle_pct = 75;
					recv_idle_pct = 27;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				// long receiver hold-off while items keep coming: fill and stall
				if (ph == 0 && k == 2 * PER_PHASE / 3)
					hold_req = 1'b1;
				send_random();
			end
			drain();
		end

		$display("Sent %0d items across %0d calibration sets, with idle mixes and a stall.",
			items_sent, cal_sets);
		$display("Sets covered reset zeros, typical values, all ones and random words.");
		if (fails == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("Timeout with %0d results outstanding", pending);
		$display("Mismatches found");
		$finish;
	end

endmodule
